// ===== rtl/core/asla_pkg.sv =====
// ----------------------------------------------------------------------------
// asla_pkg
// Shared types and constants of the async slice lane allocator.
// ----------------------------------------------------------------------------
package asla_pkg;

    localparam int MAX_SETS      = 16;
    localparam int LANES_PER_SET = 16;
    localparam int SET_W         = $clog2(MAX_SETS);
    localparam int LANE_W        = $clog2(LANES_PER_SET);
    localparam int FLAT_W        = SET_W + LANE_W;
    localparam int TOTAL_LANES   = MAX_SETS * LANES_PER_SET;
    localparam int SCNT_W        = $clog2(MAX_SETS + 1);
    localparam int LCNT_W        = $clog2(LANES_PER_SET + 1);
    localparam int SCAN_W        = (SCNT_W > LCNT_W) ? SCNT_W : LCNT_W;

    // lane word: timed flag, key, nesting, id
    localparam int LANE_DW = 1 + 64 + 8 + 8;
    // set word: kind, process, label
    localparam int SET_DW  = 1 + 16 + 32;

    typedef enum logic [2:0] {
        REQ_INTERN_SAT   = 3'd0,
        REQ_INTERN_UNNEST = 3'd1,
        REQ_BEGIN        = 3'd2,
        REQ_END          = 3'd3,
        REQ_SCOPED       = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_UNKNOWN    = 2'd1,
        ST_SETS_FULL  = 2'd2,
        ST_LANES_FULL = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SREAD,
        S_SCHECK,
        S_SADD,
        S_LSTART,
        S_L1READ,
        S_L1CHECK,
        S_L2READ,
        S_L2CHECK,
        S_APPEND,
        S_UPDATE,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch;        // capture request
        logic clr_idx;      // scan index to zero
        logic inc_idx;      // next entry
        logic set_rd;       // read set entry at index
        logic set_add;      // append set
        logic lane_rd;      // read lane entry at index
        logic adopt_idx;    // pick scanned lane as target
        logic append;       // append lane as target
        logic update;       // write target lane and result
        logic fail;         // done with error status
        status_t fail_code;
        logic intern_hit;   // result is scanned set index
        logic done;         // strobe result
    } asla_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_intern;
        logic is_scoped;
        logic is_cookie;
        logic valid_req;
        logic set_known;
        logic set_end;      // index reached sets_used
        logic set_match;
        logic sets_full;
        logic lane_end;     // index reached lanes_used
        logic l1_match;
        logic l2_match;
        logic lanes_full;
    } asla_sts_t;

endpackage

// ===== rtl/core/asla_ram.sv =====
// ----------------------------------------------------------------------------
// asla_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module asla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/asla_ctrl.sv =====
// ----------------------------------------------------------------------------
// asla_ctrl
// Sequencer: set scan, two lane scans, append and write-back.
// ----------------------------------------------------------------------------
module asla_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  asla_pkg::asla_sts_t sts,
    output asla_pkg::asla_cmd_t cmd
);
    import asla_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LSTART;
                end
            end
            S_LSTART:
            begin
                if (sts.is_intern)
                begin
                    state_next = sts.set_end ? S_SADD : S_SREAD;
                end
                else if (!sts.valid_req || !sts.set_known)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = sts.lane_end ? (sts.is_scoped ? S_APPEND : S_L2READ)
                                              : S_L1READ;
                end
            end
            S_SREAD:   state_next = S_SCHECK;
            S_SCHECK:
            begin
                if (sts.set_match)      state_next = S_DONE;
                else if (sts.set_end)   state_next = S_SADD;
                else                    state_next = S_SREAD;
            end
            S_SADD:    state_next = S_DONE;
            S_L1READ:  state_next = S_L1CHECK;
            S_L1CHECK:
            begin
                if (sts.l1_match)       state_next = S_UPDATE;
                else if (!sts.lane_end) state_next = S_L1READ;
                else if (sts.is_scoped) state_next = S_APPEND;
                else                    state_next = S_L2READ;
            end
            S_L2READ:
            begin
                state_next = sts.lane_end ? S_APPEND : S_L2CHECK;
            end
            S_L2CHECK:
            begin
                if (sts.l2_match)       state_next = S_UPDATE;
                else                    state_next = S_L2READ;
            end
            S_APPEND:
            begin
                state_next = sts.lanes_full ? S_DONE : S_UPDATE;
            end
            S_UPDATE:  state_next = S_DONE;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch   = start;
                cmd.clr_idx = start;
            end
            S_LSTART:
            begin
                cmd.set_rd  = sts.is_intern && !sts.set_end;
                cmd.lane_rd = !sts.is_intern;
                if (!sts.is_intern && sts.valid_req && !sts.set_known)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ST_UNKNOWN;
                end
                else if (!sts.is_intern && !sts.valid_req)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ST_OK;
                end
            end
            S_SREAD:
            begin
                cmd.inc_idx = 1'b1;
            end
            S_SCHECK:
            begin
                if (sts.set_match)
                begin
                    cmd.intern_hit = 1'b1;
                end
                else
                begin
                    cmd.set_rd = 1'b1;
                end
            end
            S_SADD:
            begin
                if (sts.sets_full)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ST_SETS_FULL;
                end
                else
                begin
                    cmd.set_add = 1'b1;
                end
            end
            S_L1READ:
            begin
                cmd.inc_idx = 1'b1;
            end
            S_L1CHECK:
            begin
                if (sts.l1_match)
                begin
                    cmd.adopt_idx = 1'b1;
                end
                else if (!sts.lane_end)
                begin
                    cmd.lane_rd = 1'b1;
                end
                else
                begin
                    cmd.clr_idx = 1'b1;
                end
            end
            S_L2READ:
            begin
                cmd.lane_rd = 1'b1;
                cmd.inc_idx = !sts.lane_end;
            end
            S_L2CHECK:
            begin
                cmd.adopt_idx = sts.l2_match;
            end
            S_APPEND:
            begin
                if (sts.lanes_full)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ST_LANES_FULL;
                end
                else
                begin
                    cmd.append = 1'b1;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            S_DONE:
            begin
                cmd.done = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a result strobe always closes a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |=> !busy)
        else $error("asla_ctrl: still busy after result");

    // a transfer only starts from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |-> $past(state_reg) != S_LSTART || !busy)
        else $error("asla_ctrl: latch while working");

    // write-back follows a chosen lane
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> ($past(state_reg) == S_L1CHECK || $past(state_reg) == S_L2CHECK
                        || $past(state_reg) == S_APPEND))
        else $error("asla_ctrl: update without target");
`endif

endmodule

// ===== rtl/core/asla_dp.sv =====
// ----------------------------------------------------------------------------
// asla_dp
// Datapath: request registers, set and lane tables, counters and result.
// ----------------------------------------------------------------------------
module asla_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          req_type,
    input  logic [15:0]         process_id,
    input  logic [31:0]         name_key,
    input  logic [3:0]          set_number,
    input  logic signed [63:0]  slice_cookie,
    input  logic signed [63:0]  start_time,
    input  logic signed [63:0]  duration,
    input  asla_pkg::asla_cmd_t cmd,
    output asla_pkg::asla_sts_t sts,
    output logic                done,
    output logic [7:0]          result_id,
    output logic [1:0]          status
);
    import asla_pkg::*;

    logic [2:0]             req_reg;
    logic [15:0]            pid_reg;
    logic [31:0]            name_reg;
    logic [SET_W-1:0]       sn_reg;
    logic [63:0]            cookie_reg;
    logic [63:0]            ts_reg;
    logic [63:0]            end_reg;
    logic [SCAN_W-1:0]      idx_reg, idx_next;
    logic [SCAN_W-1:0]      ridx_reg;
    logic [LANE_W-1:0]      tgt_reg;
    logic [SCNT_W-1:0]      sets_used_reg;
    logic [LCNT_W-1:0]      lanes_used_reg [MAX_SETS];
    logic [8:0]             next_id_reg;
    logic                   kind_reg;
    logic [LANE_DW-1:0]     tgt_word_reg;
    logic                   done_reg;
    logic [7:0]             rid_reg;
    logic [1:0]             st_reg;

    logic [SET_DW-1:0]      set_wdata, set_rdata;
    logic [SET_W-1:0]       set_addr;
    logic                   set_we;
    logic [LANE_DW-1:0]     lane_wdata, lane_rdata;
    logic [FLAT_W-1:0]      lane_addr;
    logic                   lane_we;
    logic [LCNT_W-1:0]      n_lanes;
    logic                   r_timed;
    logic [63:0]            r_key;
    logic [7:0]             r_nest;
    logic [7:0]             r_id;
    logic [7:0]             t_nest;
    logic [7:0]             nest_new;
    logic                   intern_req;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg    <= req_type;
            pid_reg    <= process_id;
            name_reg   <= name_key;
            sn_reg     <= set_number[SET_W-1:0];
            cookie_reg <= slice_cookie;
            ts_reg     <= start_time;
            end_reg    <= start_time + duration;
        end
    end

    assign intern_req = (req_reg == REQ_INTERN_SAT) || (req_reg == REQ_INTERN_UNNEST);
    assign n_lanes    = lanes_used_reg[sn_reg];

    // scan index; ridx remembers the entry in flight
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.clr_idx)
        begin
            idx_next = '0;
        end
        else if (cmd.inc_idx)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_rd || cmd.lane_rd)
        begin
            ridx_reg <= idx_reg;
        end
    end

    // set table
    assign set_we    = cmd.set_add;
    assign set_addr  = set_we ? sets_used_reg[SET_W-1:0] : idx_reg[SET_W-1:0];
    assign set_wdata = {req_reg[0], pid_reg, name_reg};

    asla_ram #(.WIDTH(SET_DW), .DEPTH(MAX_SETS)) u_set_ram (
        .clk   (clk),
        .we    (set_we),
        .addr  (set_addr),
        .wdata (set_wdata),
        .rdata (set_rdata)
    );

    // set kind of the request's set, read back continuously at its set number
    asla_ram #(.WIDTH(1), .DEPTH(MAX_SETS)) u_kind_ram (
        .clk   (clk),
        .we    (set_we),
        .addr  (set_we ? sets_used_reg[SET_W-1:0] : sn_reg),
        .wdata (req_reg[0]),
        .rdata (kind_reg)
    );

    // lane table
    assign {r_timed, r_key, r_nest, r_id} = lane_rdata;
    assign t_nest = tgt_word_reg[15:8];

    always_comb
    begin
        if (req_reg == REQ_BEGIN)
        begin
            if (!kind_reg)
            begin
                nest_new = 8'd1;
            end
            else
            begin
                nest_new = (t_nest == 8'hFF) ? t_nest : t_nest + 8'd1;
            end
        end
        else if (req_reg == REQ_END)
        begin
            nest_new = (t_nest != 8'd0) ? t_nest - 8'd1 : t_nest;
        end
        else
        begin
            nest_new = t_nest;
        end
    end

    assign lane_we    = cmd.update;
    assign lane_addr  = lane_we ? {sn_reg, tgt_reg} : {sn_reg, idx_reg[LANE_W-1:0]};
    assign lane_wdata = {tgt_word_reg[LANE_DW-1:16], nest_new, tgt_word_reg[7:0]};

    asla_ram #(.WIDTH(LANE_DW), .DEPTH(TOTAL_LANES)) u_lane_ram (
        .clk   (clk),
        .we    (lane_we),
        .addr  (lane_addr),
        .wdata (lane_wdata),
        .rdata (lane_rdata)
    );

    // target lane word
    always_ff @(posedge clk)
    begin
        if (cmd.adopt_idx)
        begin
            tgt_reg      <= ridx_reg[LANE_W-1:0];
            tgt_word_reg <= (req_reg == REQ_SCOPED) ? lane_rdata
                          : {1'b0, cookie_reg, r_nest, r_id};
        end
        else if (cmd.append)
        begin
            tgt_reg      <= n_lanes[LANE_W-1:0];
            tgt_word_reg <= (req_reg == REQ_SCOPED) ? {1'b1, end_reg, 8'd0, next_id_reg[7:0]}
                          : {1'b0, cookie_reg, 8'd0, next_id_reg[7:0]};
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sets_used_reg <= '0;
            next_id_reg   <= '0;
            for (int i = 0; i < MAX_SETS; i++)
            begin
                lanes_used_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.set_add)
            begin
                sets_used_reg <= sets_used_reg + 1'b1;
                lanes_used_reg[sets_used_reg[SET_W-1:0]] <= '0;
            end
            if (cmd.append)
            begin
                next_id_reg <= next_id_reg + 9'd1;
                lanes_used_reg[sn_reg] <= n_lanes + 1'b1;
            end
        end
    end

    // result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            rid_reg <= '0;
            st_reg  <= ST_OK;
        end
        else if (cmd.fail)
        begin
            rid_reg <= '0;
            st_reg  <= cmd.fail_code;
        end
        else if (cmd.intern_hit)
        begin
            rid_reg <= 8'(ridx_reg);
        end
        else if (cmd.set_add)
        begin
            rid_reg <= 8'(sets_used_reg);
        end
        else if (cmd.update)
        begin
            rid_reg <= tgt_word_reg[7:0];
        end
    end

    assign done      = done_reg;
    assign result_id = rid_reg;
    assign status    = st_reg;

    // status
    always_comb
    begin
        sts            = '0;
        sts.is_intern  = intern_req;
        sts.is_scoped  = (req_reg == REQ_SCOPED);
        sts.is_cookie  = (req_reg == REQ_BEGIN) || (req_reg == REQ_END);
        sts.valid_req  = sts.is_scoped || sts.is_cookie;
        sts.set_known  = SCNT_W'(sn_reg) < sets_used_reg;
        sts.set_end    = SCNT_W'(idx_reg) >= sets_used_reg;
        sts.set_match  = (set_rdata == {req_reg[0], pid_reg, name_reg});
        sts.sets_full  = sets_used_reg >= SCNT_W'(MAX_SETS);
        sts.lane_end   = LCNT_W'(idx_reg) >= n_lanes;
        sts.l1_match   = sts.is_scoped
                       ? (r_timed && ($signed(r_key) <= $signed(ts_reg)))
                       : (!r_timed && (r_key == cookie_reg));
        sts.l2_match   = !r_timed && (r_nest == 8'd0);
        sts.lanes_full = n_lanes >= LCNT_W'(LANES_PER_SET);
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        sets_used_reg <= SCNT_W'(MAX_SETS))
        else $error("asla_dp: set count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |=> lanes_used_reg[sn_reg] == $past(n_lanes) + 1'b1)
        else $error("asla_dp: lane count not advanced");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> result_id == 8'd0)
        else $error("asla_dp: error result carries an id");
`endif

endmodule

// ===== rtl/core/async_slice_lane_allocator.sv =====
// ----------------------------------------------------------------------------
// async_slice_lane_allocator
// Interns slice sets and assigns async slices to lanes.
// ----------------------------------------------------------------------------
// Usage: drive the request fields and raise start while busy is low; the
// request transfers at that edge and busy rises. One result (result_id,
// status) appears for exactly one cycle with done high; busy is already low
// in that cycle, so the next request can transfer at the edge that ends it.
// The receiver cannot stall it.
// Intern scans the sets until one matches and appends a new set on a miss;
// begin and end take up to two scans of the set's lanes, then an append when
// no lane matches, and write-back; scoped takes one scan, then an append when
// no lane matches, and write-back. One request is in flight at a time, so a
// new request transfers only once busy is low. The lane table is one
// single-port RAM, so each entry costs a read and a check.
// Reset: set count, per-set lane counts and the id counter go to zero; the
// tables need no clearing pass since only entries below the counts are read.
// ----------------------------------------------------------------------------
module async_slice_lane_allocator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic [15:0]        process_id,
    input  logic [31:0]        name_key,
    input  logic [3:0]         set_number,
    input  logic signed [63:0] slice_cookie,
    input  logic signed [63:0] start_time,
    input  logic signed [63:0] duration,
    output logic               done,
    output logic [7:0]         result_id,
    output logic [1:0]         status
);
    import asla_pkg::*;

    asla_cmd_t cmd;
    asla_sts_t sts;

    asla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    asla_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_type     (req_type),
        .process_id   (process_id),
        .name_key     (name_key),
        .set_number   (set_number),
        .slice_cookie (slice_cookie),
        .start_time   (start_time),
        .duration     (duration),
        .cmd          (cmd),
        .sts          (sts),
        .done         (done),
        .result_id    (result_id),
        .status       (status)
    );

endmodule
